// ----- rtl/kcdo_pkg.sv -----
package kcdo_pkg;

   localparam int MaxPointsDef  = 1024;
   localparam int NeighboursDef = 10;
   localparam int CoordBitsDef  = 24;

   localparam int DistBits = 50;
   localparam int ThrBits  = 48;
   localparam int CntBits  = 11;
   localparam int IdxBits  = 10;

   localparam logic [DistBits-1:0] DistMax = {DistBits{1'b1}};

   localparam logic [0:0] OpLoad  = 1'b0;
   localparam logic [0:0] OpQuery = 1'b1;

   localparam logic [0:0] RegPointCount = 1'b0;
   localparam logic [0:0] RegThreshold  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREAD,
      ST_PLATCH,
      ST_SCAN,
      ST_SDRAIN,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_DIV,
      ST_FIN_D,
      ST_FIN_S,
      ST_OUT
   } state_type;

   // Square of a signed difference, saturated once the magnitude reaches 2^25.
   function automatic logic [DistBits-1:0] sq_sat(input logic signed [33:0] d);
      logic [33:0] m;
      logic [49:0] p;
      m = d[33] ? 34'(-d) : 34'(d);
      p = '0;
      if (m >= 34'd33554432) begin
         p = DistMax;
      end else begin
         p = 50'(m[24:0]) * 50'(m[24:0]);
      end
      return p;
   endfunction

endpackage

// ----- rtl/knn_centroid_distance_outlier.sv -----
// Channel  Dir  Ports                    Payload
// req      in   req_tvalid/tready/tdata  op, point_index, x, y, z
// rsp      out  rsp_tvalid/tready/tdata  queried_index, centroid_dist_sq, is_outlier
// csr      in   csr_we/csr_index/csr_wdata  point_count, outlier_threshold_sq
// A load writes the point store from the idle state. A query reads the query point,
// scans the store, sums the neighbours and divides per axis before it answers:
// the single distance unit scans the store one point per cycle, each neighbour is
// summed in read and accumulate states; the restoring divider works axis by axis.
// A query with K of zero skips the scan, the sums and the divider.
// Reset is synchronous; the point store is not cleared.
// While a response waits on rsp_tready the block takes no new request.
module knn_centroid_distance_outlier
   import kcdo_pkg::*;
#(
   parameter int MAX_POINTS = MaxPointsDef,
   parameter int NEIGHBOURS = NeighboursDef,
   parameter int COORD_BITS = CoordBitsDef
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // op[0], point_index[10:1], coord_x, coord_y, coord_z, zero pad
   input  logic [((11 + 3*COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // queried_index[9:0], centroid_dist_sq[59:10], is_outlier[60], zero pad
   output logic [63:0] rsp_tdata,
   input  logic csr_we,
   input  logic [0:0] csr_index,
   input  logic [ThrBits-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int KW = $clog2(NEIGHBOURS + 1);
   localparam int NW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
   localparam int SW = COORD_BITS + KW;
   localparam int DB = SW;

   // Configuration.
   logic [CntBits-1:0] cnt_ff;
   logic [ThrBits-1:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CntBits'(1);
         thr_ff <= ThrBits'(212);
      end else if (csr_we) begin
         if (csr_index == RegPointCount) cnt_ff <= csr_wdata[CntBits-1:0];
         else thr_ff <= csr_wdata;
      end
   end

   // Request fields.
   logic in_op;
   logic [IdxBits-1:0] in_idx;
   logic [COORD_BITS-1:0] in_x, in_y, in_z;
   assign in_op  = req_tdata[0];
   assign in_idx = req_tdata[10:1];
   assign in_x   = req_tdata[11 +: COORD_BITS];
   assign in_y   = req_tdata[11 + COORD_BITS +: COORD_BITS];
   assign in_z   = req_tdata[11 + 2*COORD_BITS +: COORD_BITS];

   // Point store, one read port.
   logic [3*COORD_BITS-1:0] store_mem [MAX_POINTS];
   logic [3*COORD_BITS-1:0] rd_ff;
   logic                    st_we;
   logic [AW-1:0]           st_wa, rd_a;
   logic [3*COORD_BITS-1:0] st_wd;
   always_ff @(posedge clock) begin
      if (st_we) store_mem[st_wa] <= st_wd;
      rd_ff <= store_mem[rd_a];
   end

   state_type state_ff, state_in;
   logic [IdxBits-1:0] qidx_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff, pz_ff;
   logic [KW-1:0] k_ff, k_in;
   logic [CntBits-1:0] n_ff, n_in;   // effective count
   logic [CntBits-1:0] j_ff, j_in;   // scan index issued
   logic [CntBits-1:0] jd_ff;        // index of data in rd_ff
   logic                rv_ff;
   logic [DistBits-1:0] bd_ff [NEIGHBOURS];
   logic [AW-1:0]       bi_ff [NEIGHBOURS];
   logic signed [SW-1:0] sx_ff, sy_ff, sz_ff;
   logic [NW-1:0]       t_ff, t_in;
   logic [1:0]          ax_ff, ax_in;
   logic [5:0]          dc_ff, dc_in;
   logic [DB-1:0]       rem_ff, quo_ff, mag_ff;
   logic                neg_ff;
   logic signed [COORD_BITS+KW:0] cx_ff, cy_ff, cz_ff;
   logic [DistBits-1:0] res_ff;
   logic                rsp_v_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // Shared distance unit: the query point against the stored point in rd_ff during
   // the scan, and against the centroid in the final step.
   logic signed [COORD_BITS-1:0] rx, ry, rz;
   logic signed [33:0] ox, oy, oz;
   logic [DistBits-1:0] dsum, dsat;
   logic [DistBits+1:0] dwide;
   assign rx = rd_ff[0 +: COORD_BITS];
   assign ry = rd_ff[COORD_BITS +: COORD_BITS];
   assign rz = rd_ff[2*COORD_BITS +: COORD_BITS];
   assign ox = (state_ff == ST_FIN_D) ? 34'(cx_ff) : 34'(rx);
   assign oy = (state_ff == ST_FIN_D) ? 34'(cy_ff) : 34'(ry);
   assign oz = (state_ff == ST_FIN_D) ? 34'(cz_ff) : 34'(rz);
   assign dwide = 52'(sq_sat(ox - 34'(px_ff))) + 52'(sq_sat(oy - 34'(py_ff)))
                + 52'(sq_sat(oz - 34'(pz_ff)));
   assign dsum = dwide[DistBits-1:0];
   assign dsat = (dwide > 52'(DistMax)) ? DistMax : dsum;
   logic [DistBits-1:0] dist_ff;
   logic dv_ff;
   logic [AW-1:0] di_ff;

   // Next state and sequencing.
   logic [CntBits-1:0] cnt_sat;
   logic [CntBits+2:0] k6;
   always_comb begin
      cnt_sat = (32'(cnt_ff) > MAX_POINTS) ? CntBits'(MAX_POINTS) : cnt_ff;
      k6 = (CntBits+3)'(cnt_sat) * (CntBits+3)'(6);
      state_in = state_ff;
      k_in = k_ff; n_in = n_ff; j_in = j_ff; t_in = t_ff; ax_in = ax_ff; dc_in = dc_ff;
      st_we = 1'b0;
      st_wa = AW'(in_idx);
      st_wd = {in_z, in_y, in_x};
      rd_a = AW'(qidx_ff);
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (in_op == OpLoad) st_we = 1'b1;
               else begin
                  n_in = cnt_sat;
                  k_in = (32'(cnt_sat) >= NEIGHBOURS) ? KW'(NEIGHBOURS)
                       : KW'((32'(k6) * 32'd6554) >> 16);
                  state_in = ST_PREAD;
               end
            end
         end
         ST_PREAD: state_in = ST_PLATCH;
         ST_PLATCH: begin
            j_in = '0;
            state_in = (k_ff == '0) ? ST_OUT : ST_SCAN;
         end
         ST_SCAN: begin
            rd_a = AW'(j_ff);
            j_in = j_ff + 1'b1;
            if (j_ff + 1'b1 == n_ff) state_in = ST_SDRAIN;
         end
         ST_SDRAIN: begin
            if (!rv_ff && !dv_ff) begin
               t_in = '0; ax_in = '0;
               state_in = ST_SUM_RD;
            end
         end
         ST_SUM_RD: begin
            rd_a = bi_ff[t_ff];
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            if (32'(t_ff) + 1 >= 32'(k_ff)) begin
               ax_in = '0; dc_in = '0;
               state_in = ST_DIV;
            end else begin
               t_in = t_ff + 1'b1;
               state_in = ST_SUM_RD;
            end
         end
         ST_DIV: begin
            dc_in = dc_ff + 1'b1;
            if (32'(dc_ff) == DB + 1) begin
               dc_in = '0;
               ax_in = ax_ff + 1'b1;
               if (ax_ff == 2'd2) state_in = ST_FIN_D;
            end
         end
         ST_FIN_D: state_in = ST_FIN_S;
         ST_FIN_S: state_in = ST_OUT;
         ST_OUT: if (rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in; n_ff <= n_in; j_ff <= j_in; t_ff <= t_in; ax_ff <= ax_in; dc_ff <= dc_in;
      if (state_ff == ST_IDLE && req_tvalid) qidx_ff <= in_idx;
      if (state_ff == ST_PLATCH) begin
         px_ff <= rx; py_ff <= ry; pz_ff <= rz;
      end
   end

   // Scan pipeline: read, distance, insert.
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0; dv_ff <= 1'b0;
      end else begin
         rv_ff <= (state_ff == ST_SCAN);
         dv_ff <= rv_ff;
      end
      jd_ff <= j_ff;
      dist_ff <= dsat;
      di_ff <= AW'(jd_ff);
   end

   // Sorted insertion: strict compare keeps ties on the lower index.
   logic [NEIGHBOURS-1:0] gt;
   always_comb begin
      for (int i = 0; i < NEIGHBOURS; i++)
         gt[i] = (32'(i) < 32'(k_ff)) && (bd_ff[i] > dist_ff);
   end
   always_ff @(posedge clock) begin
      if (reset || state_ff == ST_PLATCH) begin
         for (int i = 0; i < NEIGHBOURS; i++) begin
            bd_ff[i] <= DistMax; bi_ff[i] <= '0;
         end
      end else if (dv_ff) begin
         for (int i = 0; i < NEIGHBOURS; i++) begin
            if (gt[i]) begin
               if (i == 0 || !gt[(i == 0) ? 0 : i-1]) begin
                  bd_ff[i] <= dist_ff; bi_ff[i] <= di_ff;
               end else begin
                  bd_ff[i] <= bd_ff[(i == 0) ? 0 : i-1];
                  bi_ff[i] <= bi_ff[(i == 0) ? 0 : i-1];
               end
            end
         end
      end
   end

   // Centroid sums and a shared restoring divider, one quotient bit a cycle.
   logic signed [SW-1:0] dnum;
   logic [DB:0] trial;
   always_comb begin
      case (ax_ff)
         2'd0: dnum = sx_ff;
         2'd1: dnum = sy_ff;
         default: dnum = sz_ff;
      endcase
      trial = {rem_ff, mag_ff[DB-1]} - (DB+1)'(k_ff);
   end
   always_ff @(posedge clock) begin
      if (state_ff == ST_SDRAIN) begin
         sx_ff <= '0; sy_ff <= '0; sz_ff <= '0;
      end else if (state_ff == ST_SUM_ACC) begin
         sx_ff <= sx_ff + SW'(rx); sy_ff <= sy_ff + SW'(ry); sz_ff <= sz_ff + SW'(rz);
      end
      if (state_ff == ST_DIV) begin
         if (dc_ff == '0) begin
            neg_ff <= dnum[SW-1];
            mag_ff <= dnum[SW-1] ? DB'(-dnum) : DB'(dnum);
            rem_ff <= '0; quo_ff <= '0;
         end else if (32'(dc_ff) <= DB) begin
            if (!trial[DB]) begin
               rem_ff <= trial[DB-1:0]; quo_ff <= {quo_ff[DB-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[DB-2:0], mag_ff[DB-1]}; quo_ff <= {quo_ff[DB-2:0], 1'b0};
            end
            mag_ff <= {mag_ff[DB-2:0], 1'b0};
         end else begin
            case (ax_ff)
               2'd0: cx_ff <= neg_ff ? -($signed({1'b0, quo_ff})) : $signed({1'b0, quo_ff});
               2'd1: cy_ff <= neg_ff ? -($signed({1'b0, quo_ff})) : $signed({1'b0, quo_ff});
               default: cz_ff <= neg_ff ? -($signed({1'b0, quo_ff})) : $signed({1'b0, quo_ff});
            endcase
         end
      end
      if (state_ff == ST_PLATCH) res_ff <= '0;
      else if (state_ff == ST_FIN_D) res_ff <= dsat;
   end

   // Response register.
   logic out_flag;
   assign out_flag = res_ff > 50'(thr_ff);
   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else rsp_v_ff <= (state_in == ST_OUT) && !(state_ff == ST_OUT && rsp_tready);
   end
   assign rsp_tvalid = rsp_v_ff && state_ff == ST_OUT;
   assign rsp_tdata  = {3'b0, out_flag, res_ff, qidx_ff};

`ifndef NO_ASSERTIONS
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata)) else $error("response changed");
   a_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (j_ff < n_ff)) else $error("scan overrun");
`endif

endmodule
